FILE: hdl/v4fk_pkg.sv
package v4fk_pkg;

    localparam int OFFSET_WIDTH = 16;
    localparam int LEN_EXT_W    = 33;

    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] FRAG_MF     = 16'h2000;
    localparam logic [15:0] FRAG_OFFSET = 16'h1fff;
    localparam logic [3:0]  IP_VERSION  = 4'd4;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;

    localparam int ETH_HDR_LEN = 14;
    localparam int IP_MIN_LEN  = 20;
    localparam int TCP_HDR_LEN = 20;
    localparam int UDP_HDR_LEN = 8;

    localparam int POS_ETYPE_HI = 12;
    localparam int POS_ETYPE_LO = 13;
    localparam int POS_VER_IHL  = 14;
    localparam int POS_FRAG_HI  = 20;
    localparam int POS_FRAG_LO  = 21;
    localparam int POS_PROTO    = 23;
    localparam int POS_SRC_LO   = 26;
    localparam int POS_SRC_HI   = 29;
    localparam int POS_DST_LO   = 30;
    localparam int POS_DST_HI   = 33;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 128;

    typedef logic [OFFSET_WIDTH-1:0] t_offset;

    localparam t_offset OFFSET_MAX = '1;

    typedef enum logic [2:0] {
        ST_TCP   = 3'd0,
        ST_UDP   = 3'd1,
        ST_PARSE = 3'd2,
        ST_ETH   = 3'd3,
        ST_IP    = 3'd4,
        ST_FRAG  = 3'd5
    } t_status;

    typedef struct packed {
        t_offset     len;
        logic [15:0] ether_type;
        logic [7:0]  ver_ihl;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] ports;
    } t_hdr;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [7:0]  protocol_number;
        logic [31:0] dest_address;
        logic [31:0] source_address;
        logic        ipv4_parsed;
        t_status     status;
    } t_verdict;

endpackage

FILE: hdl/v4fk_capture.sv
module v4fk_capture (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output v4fk_pkg::t_hdr o_hdr
);
    import v4fk_pkg::*;

    t_hdr        r_hdr;
    t_hdr        n_hdr;
    t_offset     pos;
    logic [7:0]  l4_start;
    logic [7:0]  l4_end;

    assign pos      = r_hdr.len;
    assign l4_start = 8'(ETH_HDR_LEN) + {2'b00, r_hdr.ver_ihl[3:0], 2'b00};
    assign l4_end   = l4_start + 8'd4;

    always_comb begin
        n_hdr = r_hdr;
        if (pos == t_offset'(POS_ETYPE_HI) || pos == t_offset'(POS_ETYPE_LO)) begin
            n_hdr.ether_type = {r_hdr.ether_type[7:0], i_byte};
        end else if (pos == t_offset'(POS_VER_IHL)) begin
            n_hdr.ver_ihl = i_byte;
        end else if (pos == t_offset'(POS_FRAG_HI) || pos == t_offset'(POS_FRAG_LO)) begin
            n_hdr.frag = {r_hdr.frag[7:0], i_byte};
        end else if (pos == t_offset'(POS_PROTO)) begin
            n_hdr.proto = i_byte;
        end else if (pos >= t_offset'(POS_SRC_LO) && pos <= t_offset'(POS_SRC_HI)) begin
            n_hdr.src = {r_hdr.src[23:0], i_byte};
        end else if (pos >= t_offset'(POS_DST_LO) && pos <= t_offset'(POS_DST_HI)) begin
            n_hdr.dst = {r_hdr.dst[23:0], i_byte};
        end
        if (pos > t_offset'(ETH_HDR_LEN) && pos >= t_offset'(l4_start)
                && pos < t_offset'(l4_end)) begin
            n_hdr.ports = {r_hdr.ports[23:0], i_byte};
        end
        if (r_hdr.len != OFFSET_MAX) begin
            n_hdr.len = r_hdr.len + t_offset'(1);
        end
    end

    assign o_hdr = n_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_hdr <= '0;
            end else begin
                r_hdr <= n_hdr;
            end
        end
    end

endmodule

FILE: hdl/v4fk_verdict.sv
module v4fk_verdict (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_take,
    input  v4fk_pkg::t_hdr     i_hdr,
    output logic               o_valid,
    output v4fk_pkg::t_verdict o_verdict
);
    import v4fk_pkg::*;

    t_verdict               r_verdict;
    t_verdict               n_verdict;
    logic                   r_valid;
    logic [LEN_EXT_W-1:0]   len;
    logic [LEN_EXT_W-1:0]   ihl4;
    logic [LEN_EXT_W-1:0]   ip_end;

    assign len    = LEN_EXT_W'(i_hdr.len);
    assign ihl4   = LEN_EXT_W'({i_hdr.ver_ihl[3:0], 2'b00});
    assign ip_end = LEN_EXT_W'(ETH_HDR_LEN) + ihl4;

    always_comb begin
        n_verdict = '0;
        n_verdict.frame_length = (len > LEN_EXT_W'(16'hffff)) ? 16'hffff : len[15:0];
        if (len < LEN_EXT_W'(ETH_HDR_LEN)) begin
            n_verdict.status = ST_PARSE;
        end else if (i_hdr.ether_type != ETYPE_IPV4) begin
            n_verdict.status = ST_ETH;
        end else if (len < LEN_EXT_W'(ETH_HDR_LEN + IP_MIN_LEN)) begin
            n_verdict.status = ST_PARSE;
        end else if (i_hdr.ver_ihl[7:4] != IP_VERSION) begin
            n_verdict.status = ST_IP;
        end else if ((i_hdr.frag & (FRAG_MF | FRAG_OFFSET)) != 16'h0000) begin
            n_verdict.status = ST_FRAG;
        end else if (ihl4 < LEN_EXT_W'(IP_MIN_LEN)) begin
            n_verdict.status = ST_PARSE;
        end else if (len < ip_end) begin
            n_verdict.status = ST_PARSE;
        end else begin
            n_verdict.ipv4_parsed     = 1'b1;
            n_verdict.source_address  = i_hdr.src;
            n_verdict.dest_address    = i_hdr.dst;
            n_verdict.protocol_number = i_hdr.proto;
            if (i_hdr.proto == PROTO_TCP) begin
                if (len < ip_end + LEN_EXT_W'(TCP_HDR_LEN)) begin
                    n_verdict.status = ST_PARSE;
                end else begin
                    n_verdict.status      = ST_TCP;
                    n_verdict.source_port = i_hdr.ports[31:16];
                    n_verdict.dest_port   = i_hdr.ports[15:0];
                end
            end else if (i_hdr.proto == PROTO_UDP) begin
                if (len < ip_end + LEN_EXT_W'(UDP_HDR_LEN)) begin
                    n_verdict.status = ST_PARSE;
                end else begin
                    n_verdict.status      = ST_UDP;
                    n_verdict.source_port = i_hdr.ports[31:16];
                    n_verdict.dest_port   = i_hdr.ports[15:0];
                end
            end else begin
                n_verdict.status = ST_IP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

endmodule

FILE: hdl/ipv4_flow_key_parser.sv
// IPv4 flow key parser.
// Slave side: one Ethernet frame byte per request on s_tdata, starting at the
// destination MAC address, with s_tlast on the final byte of the frame.
// Master side: one verdict per frame, on m_tdata, carrying the status, the
// IPv4 addresses and protocol, the L4 ports and the frame length.
// The verdict is presented in the cycle after the last byte is taken.
// Throughput: one byte per cycle unless a final byte is held back, including
// the next frame's first byte right behind the previous frame's last byte.
// Header fields are captured on the fly by a byte counter and compared
// against the header positions (L4 ports via the IHL); the verdict is made in
// the same cycle as the last byte and held in the output register.
// Stall: while a verdict waits on m_tready, non-final bytes are still
// taken; only a final byte is held back until the waiting verdict leaves.
// Reset (synchronous, active low) clears the byte counter, the captured
// fields and the output valid; the block takes bytes in the next cycle.
module ipv4_flow_key_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [v4fk_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] pkt_byte
    input  logic                               s_tlast,  // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] status, [3] ipv4_parsed, [35:4] source_address,
    // [67:36] dest_address, [75:68] protocol_number, [91:76] source_port,
    // [107:92] dest_port, [123:108] frame_length, [127:124] zero
    output logic [v4fk_pkg::M_TDATA_W-1:0]     m_tdata
);
    import v4fk_pkg::*;

    logic     accept;
    t_hdr     hdr;
    t_verdict verdict;

    assign s_tready = !s_tlast || !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    v4fk_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .o_hdr    (hdr)
    );

    v4fk_verdict u_verdict (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept && s_tlast),
        .i_take    (m_tready),
        .i_hdr     (hdr),
        .o_valid   (m_tvalid),
        .o_verdict (verdict)
    );

    assign m_tdata = M_TDATA_W'(verdict);

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import v4fk_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    typedef enum int {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH_IDLE
    } t_idle_phase;

    localparam int FRAMES_PER_PHASE = 6;

    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    t_frame_byte tx_bytes[$];
    t_verdict    pending_verdicts[$];
    int          frames_sent;
    int          bytes_queued;
    int          error_count;

    t_offset     fk_count;
    logic [15:0] fk_etype;
    logic [7:0]  fk_vihl;
    logic [15:0] fk_frag;
    logic [7:0]  fk_proto;
    logic [31:0] fk_src;
    logic [31:0] fk_dst;
    logic [31:0] fk_ports;

    ipv4_flow_key_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_idle_phase load_phase();
        return t_idle_phase'((frames_sent / FRAMES_PER_PHASE) % 4);
    endfunction

    function automatic bit sender_pause();
        case (load_phase())
            PH_SRC_IDLE:  return $urandom_range(0, 99) < 57;
            PH_BOTH_IDLE: return $urandom_range(0, 99) < 24;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (load_phase())
            PH_SINK_STALL: return $urandom_range(0, 99) < 57;
            PH_BOTH_IDLE:  return $urandom_range(0, 99) < 24;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic clear_flow_key();
        fk_count = '0;
        fk_etype = '0;
        fk_vihl  = '0;
        fk_frag  = '0;
        fk_proto = '0;
        fk_src   = '0;
        fk_dst   = '0;
        fk_ports = '0;
    endtask

    task automatic advance_flow_key(input logic [7:0] b, input logic last);
        longint   pos;
        longint   l4;
        longint   len;
        longint   ihl4;
        longint   l4_need;
        t_verdict v;
        pos = longint'(fk_count);
        ihl4 = 4 * longint'(fk_vihl[3:0]);
        l4 = ETH_HDR_LEN + ihl4;
        if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO) begin
            fk_etype = {fk_etype[7:0], b};
        end else if (pos == POS_VER_IHL) begin
            fk_vihl = b;
        end else if (pos == POS_FRAG_HI || pos == POS_FRAG_LO) begin
            fk_frag = {fk_frag[7:0], b};
        end else if (pos == POS_PROTO) begin
            fk_proto = b;
        end else if (pos >= POS_SRC_LO && pos <= POS_SRC_HI) begin
            fk_src = {fk_src[23:0], b};
        end else if (pos >= POS_DST_LO && pos <= POS_DST_HI) begin
            fk_dst = {fk_dst[23:0], b};
        end
        if (pos > ETH_HDR_LEN && pos >= l4 && pos < l4 + 4) begin
            fk_ports = {fk_ports[23:0], b};
        end
        if (fk_count != OFFSET_MAX) begin
            fk_count = fk_count + t_offset'(1);
        end
        if (last) begin
            len = longint'(fk_count);
            ihl4 = 4 * longint'(fk_vihl[3:0]);
            v = '0;
            v.frame_length = (len > 65535) ? 16'hffff : 16'(len);
            if (len < ETH_HDR_LEN) begin
                v.status = ST_PARSE;
            end else if (fk_etype != ETYPE_IPV4) begin
                v.status = ST_ETH;
            end else if (len < ETH_HDR_LEN + IP_MIN_LEN) begin
                v.status = ST_PARSE;
            end else if (fk_vihl[7:4] != IP_VERSION) begin
                v.status = ST_IP;
            end else if ((fk_frag & (FRAG_MF | FRAG_OFFSET)) != 16'h0) begin
                v.status = ST_FRAG;
            end else if (ihl4 < IP_MIN_LEN || len < ETH_HDR_LEN + ihl4) begin
                v.status = ST_PARSE;
            end else begin
                v.ipv4_parsed     = 1'b1;
                v.source_address  = fk_src;
                v.dest_address    = fk_dst;
                v.protocol_number = fk_proto;
                if (fk_proto == PROTO_TCP || fk_proto == PROTO_UDP) begin
                    l4_need = ETH_HDR_LEN + ihl4 +
                              ((fk_proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN);
                    if (len < l4_need) begin
                        v.status = ST_PARSE;
                    end else begin
                        v.status      = (fk_proto == PROTO_TCP) ? ST_TCP : ST_UDP;
                        v.source_port = fk_ports[31:16];
                        v.dest_port   = fk_ports[15:0];
                    end
                end else begin
                    v.status = ST_IP;
                end
            end
            pending_verdicts.push_back(v);
            clear_flow_key();
        end
    endtask

    task automatic queue_frame(input int len, input logic [15:0] etype,
                               input logic [7:0] vihl, input logic [15:0] frag,
                               input logic [7:0] proto, input int fill);
        t_frame_byte fb;
        int          i;
        for (i = 0; i < len; i++) begin
            fb.data = (fill < 0) ? 8'($urandom) : 8'(fill);
            case (i)
                POS_ETYPE_HI: fb.data = etype[15:8];
                POS_ETYPE_LO: fb.data = etype[7:0];
                POS_VER_IHL:  fb.data = vihl;
                POS_FRAG_HI:  fb.data = frag[15:8];
                POS_FRAG_LO:  fb.data = frag[7:0];
                POS_PROTO:    fb.data = proto;
                default: ;
            endcase
            fb.last = (i == len - 1);
            tx_bytes.push_back(fb);
        end
        bytes_queued += len;
    endtask

    task automatic queue_random_frame();
        int          ihl;
        int          need;
        int          len;
        int          pick;
        logic [7:0]  proto;
        logic [15:0] frag;
        if ($urandom_range(0, 99) < 70) begin
            ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
            pick = $urandom_range(0, 9);
            proto = (pick < 5) ? PROTO_TCP : (pick < 9) ? PROTO_UDP : 8'($urandom);
            frag = {2'($urandom), 14'h0};
            need = ETH_HDR_LEN + 4 * ihl +
                   ((proto == PROTO_UDP) ? UDP_HDR_LEN : TCP_HDR_LEN);
            if ($urandom_range(0, 7) == 0) begin
                len = need - $urandom_range(1, 4);
            end else begin
                len = need + $urandom_range(0, 24);
            end
            queue_frame(len, ETYPE_IPV4, {IP_VERSION, 4'(ihl)}, frag, proto, -1);
        end else begin
            len  = $urandom_range(1, 70);
            frag = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'($urandom);
            queue_frame(len,
                        ($urandom_range(0, 3) == 0) ? 16'($urandom) : ETYPE_IPV4,
                        8'($urandom), frag, 8'($urandom), -1);
        end
    endtask

    // hold the request until taken; predict on every accepted byte
    always @(posedge i_clk) begin
        t_frame_byte fb;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            clear_flow_key();
            frames_sent <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_flow_key(s_tdata, s_tlast);
                if (s_tlast) begin
                    frames_sent <= frames_sent + 1;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (tx_bytes.size() != 0 && !sender_pause()) begin
                    fb = tx_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= fb.data;
                    s_tlast  <= fb.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = t_verdict'(m_tdata[123:0]);
                if (pending_verdicts.size() == 0) begin
                    $error("verdict with none expected: status 0x%0h", got.status);
                    error_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("ipv4_parsed", 32'(want.ipv4_parsed), 32'(got.ipv4_parsed));
                    check_field("source_address", want.source_address, got.source_address);
                    check_field("dest_address", want.dest_address, got.dest_address);
                    check_field("protocol_number", 32'(want.protocol_number),
                                32'(got.protocol_number));
                    check_field("source_port", 32'(want.source_port), 32'(got.source_port));
                    check_field("dest_port", 32'(want.dest_port), 32'(got.dest_port));
                    check_field("frame_length", 32'(want.frame_length),
                                32'(got.frame_length));
                    check_field("padding", 32'h0, 32'(m_tdata[127:124]));
                end
            end
            m_tready <= !receiver_stall();
        end
    end

    initial begin
        bytes_queued  = 0;
        error_count   = 0;

        queue_frame(1, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00);
        queue_frame(13, 16'hffff, 8'hff, 16'hffff, 8'hff, 8'hff);
        queue_frame(14, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, -1);
        queue_frame(60, 16'h86dd, 8'h45, 16'h0000, PROTO_TCP, -1);
        queue_frame(33, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, -1);
        queue_frame(60, ETYPE_IPV4, 8'h65, 16'h0000, PROTO_TCP, -1);
        queue_frame(60, ETYPE_IPV4, 8'h45, FRAG_MF, PROTO_TCP, -1);
        queue_frame(60, ETYPE_IPV4, 8'h45, 16'h0001, PROTO_UDP, -1);
        queue_frame(60, ETYPE_IPV4, 8'h45, FRAG_OFFSET, PROTO_UDP, -1);
        queue_frame(60, ETYPE_IPV4, 8'h45, 16'h4000, PROTO_TCP, -1);
        queue_frame(60, ETYPE_IPV4, 8'h44, 16'h0000, PROTO_TCP, -1);
        queue_frame(60, ETYPE_IPV4, 8'h40, 16'h0000, PROTO_UDP, -1);
        queue_frame(73, ETYPE_IPV4, 8'h4f, 16'h0000, PROTO_TCP, -1);
        queue_frame(93, ETYPE_IPV4, 8'h4f, 16'h0000, PROTO_TCP, -1);
        queue_frame(94, ETYPE_IPV4, 8'h4f, 16'h0000, PROTO_TCP, -1);
        queue_frame(53, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, -1);
        queue_frame(54, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, 8'hff);
        queue_frame(41, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_UDP, -1);
        queue_frame(42, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_UDP, 8'h00);
        queue_frame(60, ETYPE_IPV4, 8'h45, 16'h0000, 8'd1, -1);
        queue_frame(64, ETYPE_IPV4, 8'h45, 16'h0000, 8'hff, 8'hff);
        queue_frame(64, 16'hffff, 8'hff, 16'hffff, 8'hff, 8'hff);
        queue_frame(54, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, -1);

        while (bytes_queued < 1650) begin
            queue_random_frame();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tx_bytes.size() != 0 || s_tvalid) @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/v4fk_pkg.sv
hdl/v4fk_capture.sv
hdl/v4fk_verdict.sv
hdl/ipv4_flow_key_parser.sv
tb/sv/testbench.sv
